[hdl/utf8_escape_formatter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 escape formatter
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_ESCAPE_FORMATTER_UNIT_MACROS_SVH
`define UTF8_ESCAPE_FORMATTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UEF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[hdl/uef_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 escape formatter package
// Job type passed from the decoder front end to the character emitter.
// ----------------------------------------------------------------------------
package uef_pkg;

    // Number of decoded jobs held between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int CODE_W = 21;

    // ASCII characters used by the escapes.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    // Kind of output sequence one input byte causes.
    typedef enum logic [1:0] {
        JOB_PASS = 2'b00,   // one character as is
        JOB_ESC  = 2'b01,   // backslash followed by one character
        JOB_HEX  = 2'b10    // \u{hex digits}
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [7:0]          ch;      // pass character or escaped character
        logic [CODE_W-1:0]   code;    // value for a hex escape
        logic [2:0]          ndig;    // hex digit count, 1 to 6
    } job_t;

endpackage

[hdl/utf8_escape_formatter_unit.sv]
// ----------------------------------------------------------------------------
// UTF-8 escape formatter
// Converts a byte stream into escaped text with \n, \\, \" and \u{hex}.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                 tuser  tlast
//  s_axis    in         [7:0] in_byte         -      end_of_string
//  m_axis    out        [7:0] out_char        -      last_of_run
//
//  One input byte is accepted per cycle while the four-entry job queue
//  has room; the emitter sends one character per cycle while the output
//  is not stalled, and one byte expands to at most ten characters. A
//  character passes through the job queue and then the output register
//  after its byte is accepted. rst_n clears sequence state, queue and
//  output valid at once. Output stalls fill the queue and then stall input.
// ----------------------------------------------------------------------------
module utf8_escape_formatter_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);

    logic          push;
    uef_pkg::job_t push_job;
    logic          pop;
    logic          queue_full;
    logic          head_valid;
    uef_pkg::job_t head_job;

    // Byte decoder.
    uef_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_eos     (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Job queue between decoder and emitter.
    uef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Character emitter.
    uef_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

[hdl/uef_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 escape formatter front end
// Accepts input bytes, tracks pending UTF-8 sequences and turns each byte
// into at most one output job.
// ----------------------------------------------------------------------------
module uef_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_eos,
    input  logic          queue_full,
    output logic          push,
    output uef_pkg::job_t push_job
);

    logic [1:0]                  pending_reg, pending_next;
    logic [uef_pkg::CODE_W-1:0]  accum_reg, accum_next;
    logic [uef_pkg::CODE_W-1:0]  merged;
    logic [1:0]                  pending_dec;
    logic                        job_valid;
    uef_pkg::job_t               job;
    logic                        accept;

    // Number of hex digits needed for a code point, without leading zeros.
    function automatic logic [2:0] hex_digits(input logic [uef_pkg::CODE_W-1:0] c);
        logic [2:0] n;
        begin
            if (c[20])
                n = 3'd6;
            else if (c[19:16] != 4'd0)
                n = 3'd5;
            else if (c[15:12] != 4'd0)
                n = 3'd4;
            else if (c[11:8] != 4'd0)
                n = 3'd3;
            else if (c[7:4] != 4'd0)
                n = 3'd2;
            else
                n = 3'd1;
            return n;
        end
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && job_valid;
    assign push_job = job;

    // Decode one byte against the pending sequence state.
    always_comb
    begin
        pending_next = pending_reg;
        accum_next   = accum_reg;
        job_valid    = 1'b0;
        job          = '0;
        merged       = accum_reg;
        pending_dec  = pending_reg - 2'd1;

        if (pending_reg != 2'd0 && in_byte[7:6] == 2'b10)
        begin
            // Continuation byte: merge its six payload bits.
            unique case (pending_reg)
                2'd1:    merged = accum_reg | {15'd0, in_byte[5:0]};
                2'd2:    merged = accum_reg | {9'd0, in_byte[5:0], 6'd0};
                2'd3:    merged = accum_reg | {3'd0, in_byte[5:0], 12'd0};
                default: merged = accum_reg;
            endcase
            if (pending_dec == 2'd0)
            begin
                job_valid    = 1'b1;
                job.kind     = uef_pkg::JOB_HEX;
                job.code     = merged;
                job.ndig     = hex_digits(merged);
                accum_next   = '0;
                pending_next = 2'd0;
            end
            else
            begin
                accum_next   = merged;
                pending_next = pending_dec;
            end
        end
        else
        begin
            // Lead byte; any partial sequence is discarded.
            pending_next = 2'd0;
            accum_next   = '0;
            priority if (in_byte == uef_pkg::CH_NEWLINE)
            begin
                job_valid = 1'b1;
                job.kind  = uef_pkg::JOB_ESC;
                job.ch    = uef_pkg::CH_N;
            end
            else if (in_byte == uef_pkg::CH_BACKSLASH || in_byte == uef_pkg::CH_QUOTE)
            begin
                job_valid = 1'b1;
                job.kind  = uef_pkg::JOB_ESC;
                job.ch    = in_byte;
            end
            else if (in_byte < 8'h20)
            begin
                job_valid = 1'b1;
                job.kind  = uef_pkg::JOB_HEX;
                job.code  = {13'd0, in_byte};
                job.ndig  = (in_byte[7:4] != 4'd0) ? 3'd2 : 3'd1;
            end
            else if (in_byte < 8'h80)
            begin
                job_valid = 1'b1;
                job.kind  = uef_pkg::JOB_PASS;
                job.ch    = in_byte;
            end
            else if (in_byte < 8'hC0)
            begin
                // Stray continuation byte is dropped.
                job_valid = 1'b0;
            end
            else if (in_byte < 8'hE0)
            begin
                accum_next   = {10'd0, in_byte[4:0], 6'd0};
                pending_next = 2'd1;
            end
            else if (in_byte < 8'hF0)
            begin
                accum_next   = {5'd0, in_byte[3:0], 12'd0};
                pending_next = 2'd2;
            end
            else if (in_byte < 8'hF8)
            begin
                accum_next   = {in_byte[2:0], 18'd0};
                pending_next = 2'd3;
            end
            else
            begin
                // Bytes F8 to FF are dropped.
                job_valid = 1'b0;
            end
        end

        // End of string drops any unfinished sequence.
        if (in_eos)
        begin
            pending_next = 2'd0;
            accum_next   = '0;
        end
    end

    // Sequence state advances on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            accum_reg   <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

[hdl/uef_queue.sv]
// ----------------------------------------------------------------------------
// UTF-8 escape formatter job queue
// Small FIFO of decoded jobs between the front end and the emitter.
// ----------------------------------------------------------------------------
module uef_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  uef_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output uef_pkg::job_t head_job
);

    uef_pkg::job_t                    entry_reg [uef_pkg::QUEUE_DEPTH];
    logic [uef_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [uef_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [uef_pkg::QUEUE_CW-1:0]     count_reg, count_next;

    assign full       = (count_reg == uef_pkg::QUEUE_CW'(uef_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + uef_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + uef_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + uef_pkg::QUEUE_CW'(1);
        else if (pop && !push)
            count_next = count_reg - uef_pkg::QUEUE_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[hdl/uef_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 escape formatter emitter
// Walks the job at the queue head one character per cycle into the
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module uef_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  uef_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          out_last
);

    logic [3:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load;
    logic [7:0] cur_char;
    logic       cur_last;
    logic [3:0] digit_sel;
    logic [3:0] nibble;
    logic [23:0] code_ext;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign pop       = load && cur_last;
    assign code_ext  = {3'd0, head_job.code};
    assign digit_sel = {1'b0, head_job.ndig} + 4'd2 - pos_reg;

    // Select the hex digit, most significant first.
    always_comb
    begin
        unique case (digit_sel[2:0])
            3'd0:    nibble = code_ext[3:0];
            3'd1:    nibble = code_ext[7:4];
            3'd2:    nibble = code_ext[11:8];
            3'd3:    nibble = code_ext[15:12];
            3'd4:    nibble = code_ext[19:16];
            3'd5:    nibble = code_ext[23:20];
            default: nibble = 4'd0;
        endcase
    end

    // Character at the current position of the head job.
    always_comb
    begin
        cur_char = head_job.ch;
        cur_last = 1'b0;
        unique case (head_job.kind)
            uef_pkg::JOB_PASS:
            begin
                cur_char = head_job.ch;
                cur_last = 1'b1;
            end
            uef_pkg::JOB_ESC:
            begin
                cur_char = (pos_reg == 4'd0) ? uef_pkg::CH_BACKSLASH : head_job.ch;
                cur_last = (pos_reg != 4'd0);
            end
            uef_pkg::JOB_HEX:
            begin
                priority if (pos_reg == 4'd0)
                    cur_char = uef_pkg::CH_BACKSLASH;
                else if (pos_reg == 4'd1)
                    cur_char = uef_pkg::CH_U;
                else if (pos_reg == 4'd2)
                    cur_char = uef_pkg::CH_LBRACE;
                else if (pos_reg == {1'b0, head_job.ndig} + 4'd3)
                begin
                    cur_char = uef_pkg::CH_RBRACE;
                    cur_last = 1'b1;
                end
                else if (nibble < 4'd10)
                    cur_char = 8'h30 + {4'd0, nibble};
                else
                    cur_char = 8'h57 + {4'd0, nibble};
            end
            default:
            begin
                cur_char = head_job.ch;
                cur_last = 1'b1;
            end
        endcase
    end

    // Position and output valid control.
    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            pos_next   = cur_last ? 4'd0 : pos_reg + 4'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= cur_char;
            last_reg <= cur_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

[hdl/uef_checker.sv]
// ----------------------------------------------------------------------------
// UTF-8 escape formatter port checker
// Observes the top-level ports and checks output stream properties.
// ----------------------------------------------------------------------------
`include "utf8_escape_formatter_unit_macros.svh"

module uef_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic       out_stalled;
    logic [8:0] out_word;

    // Output transaction held back by the receiver, and its full payload.
    assign out_stalled = m_tvalid && !m_tready;
    assign out_word    = {m_tlast, m_tdata};

    // A stalled output transaction keeps its payload.
    `UEF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stalled, m_tvalid && $stable(out_word))

    // Every emitted character is printable ASCII or DEL.
    `UEF_ASSERT_NOW(a_out_printable, clk, rst_n, m_tvalid, !m_tdata[7] && m_tdata[6:5] != 2'b00)

    // A run that is not finished continues in the very next cycle.
    `UEF_ASSERT_NEXT(a_run_continues, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

bind utf8_escape_formatter_unit uef_checker u_checker (.*);

[bench/tb_utf8_escape_formatter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 escape formatter
// Streams raw bytes into the formatter and checks every escaped character
// against a cycle-free software prediction of the escape rules. Directed
// cases cover escapes, control bytes, multibyte sequences and dropped bytes;
// the random part sends mostly well-formed UTF-8 with random content, mixed
// with broken sequences and noise, under random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_utf8_escape_formatter_unit;

    localparam int         CLK_PERIOD   = 20;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_ITEMS = 300;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_A_LOWER   = 8'h61;

    // One expected output character.
    typedef struct packed {
        logic [7:0] ch;
        logic       last_of_run;
    } esc_char_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // [7:0] out_char
    logic       m_tlast;

    // Expected escaped text and the decoder state of the prediction.
    esc_char_t   expected_text[$];
    logic [7:0]  step_chars[$];
    logic [1:0]  cont_left;
    logic [20:0] code_acc;

    int        n_errors    = 0;
    int        cycle_count = 0;
    int        burst_left;
    bit        calm_phase;
    int        rx_cycle    = 0;
    int        rx_mode     = 0;
    esc_char_t want;

    utf8_escape_formatter_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction of the escaped text
    // ------------------------------------------------------------------

    // Appends \u{...} with lowercase digits and no leading zeros.
    function automatic void emit_unicode_escape(input logic [20:0] val);
        logic [23:0] wide;
        logic [3:0]  nib;
        int          ndig;
        wide = {3'b000, val};
        ndig = 1;
        while (ndig < 6 && (wide >> (4 * ndig)) != 0)
            ndig++;
        step_chars.push_back(uef_pkg::CH_BACKSLASH);
        step_chars.push_back(uef_pkg::CH_U);
        step_chars.push_back(uef_pkg::CH_LBRACE);
        for (int i = ndig; i > 0; i--)
        begin
            nib = wide[4 * (i - 1) +: 4];
            step_chars.push_back(nib < 4'd10 ? CH_ZERO + nib : CH_A_LOWER + nib - 8'd10);
        end
        step_chars.push_back(uef_pkg::CH_RBRACE);
    endfunction

    // A byte seen with no sequence pending.
    function automatic void decode_lead_byte(input logic [7:0] b);
        if (b == uef_pkg::CH_NEWLINE)
        begin
            step_chars.push_back(uef_pkg::CH_BACKSLASH);
            step_chars.push_back(uef_pkg::CH_N);
        end
        else if (b == uef_pkg::CH_BACKSLASH || b == uef_pkg::CH_QUOTE)
        begin
            step_chars.push_back(uef_pkg::CH_BACKSLASH);
            step_chars.push_back(b);
        end
        else if (b < 8'h20)
            emit_unicode_escape({13'd0, b});
        else if (b < 8'h80)
            step_chars.push_back(b);
        else if (b < 8'hC0)
            ;  // stray continuation byte is dropped
        else if (b < 8'hE0)
        begin
            code_acc  = {10'd0, b[4:0], 6'd0};
            cont_left = 2'd1;
        end
        else if (b < 8'hF0)
        begin
            code_acc  = {5'd0, b[3:0], 12'd0};
            cont_left = 2'd2;
        end
        else if (b < 8'hF8)
        begin
            code_acc  = {b[2:0], 18'd0};
            cont_left = 2'd3;
        end
        // Bytes F8 to FF are dropped.
    endfunction

    // Works out the characters one accepted byte causes.
    function automatic void predict_escaped_chars(input logic [7:0] b, input logic eos);
        step_chars.delete();
        if (cont_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                code_acc  = code_acc | (21'(b[5:0]) << (6 * (cont_left - 1)));
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    emit_unicode_escape(code_acc);
                    code_acc = '0;
                end
            end
            else
            begin
                // A bad continuation restarts decoding with this byte.
                cont_left = 2'd0;
                code_acc  = '0;
                decode_lead_byte(b);
            end
        end
        else
            decode_lead_byte(b);
        if (eos)
        begin
            cont_left = 2'd0;
            code_acc  = '0;
        end
        foreach (step_chars[i])
            expected_text.push_back('{ch: step_chars[i],
                                      last_of_run: (i == step_chars.size() - 1)});
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sends one byte, with random bursts and gaps, and records its output.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = calm_phase ? 0 : $urandom_range(0, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_escaped_chars(b, eos);
    endtask

    // Holds the input idle until every expected character has come out.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    // Sends a UTF-8 sequence of nbytes with random content, cut after keep bytes.
    task automatic send_utf8(input int nbytes, input int keep, input logic eos);
        logic [7:0] lead;
        case (nbytes)
            2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
            3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        send_byte(lead, eos && keep == 1);
        for (int i = 1; i < keep; i++)
            send_byte(8'h80 | 8'($urandom_range(0, 63)), eos && i == keep - 1);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern and checking
    // ------------------------------------------------------------------

    // Ready changes mode every so often: always ready, random, sparse, periodic.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 97 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_cycle % 4 != 3);
        endcase
    end

    // Each output transaction is compared with the oldest expected character.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected output: got char %h last %b",
                         $time, m_tdata, m_tlast);
                n_errors++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (m_tdata !== want.ch)
                begin
                    $display("%0t: out_char mismatch: expected %h, got %h",
                             $time, want.ch, m_tdata);
                    n_errors++;
                end
                if (m_tlast !== want.last_of_run)
                begin
                    $display("%0t: last_of_run mismatch: expected %b, got %b",
                             $time, want.last_of_run, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d characters outstanding",
                     $time, expected_text.size());
            $display("tb_utf8_escape_formatter_unit: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Backslash escapes, control bytes, zero byte and printable edges.
    task automatic test_escapes();
        send_byte(8'h00, 1'b0);
        send_byte(uef_pkg::CH_NEWLINE, 1'b1);
        send_byte(uef_pkg::CH_BACKSLASH, 1'b0);
        send_byte(uef_pkg::CH_QUOTE, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // Two-, three- and four-byte sequences, the last one the largest code.
    task automatic test_multibyte();
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    // Stray continuation, F8 to FF, bad continuation, end of string mid-sequence.
    task automatic test_dropped_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'hA9, 1'b1);
    endtask

    // Mostly well-formed UTF-8 with random content, plus broken runs and noise.
    task automatic test_random_text();
        int         sent;
        int         kind;
        int         nbytes;
        int         keep;
        logic [7:0] b;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm_phase = ((sent / 40) % 3 == 1);
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 11) == 0);
                sent++;
            end
            else if (kind < 80)
            begin
                nbytes = (kind < 50) ? 2 : (kind < 65) ? 3 : 4;
                send_utf8(nbytes, nbytes, $urandom_range(0, 11) == 0);
                sent += nbytes;
            end
            else if (kind < 92)
            begin
                // Truncated sequence, ended either by end of string or a new lead.
                nbytes = $urandom_range(2, 4);
                keep   = $urandom_range(1, nbytes - 1);
                send_utf8(nbytes, keep, $urandom_range(0, 2) == 0);
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                send_byte(b, $urandom_range(0, 11) == 0);
                sent += keep + 1;
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
                send_byte(b, $urandom_range(0, 1) == 1);
                if (b < 8'h80 || (b >= 8'hC0 && b < 8'hF8))
                    sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        cont_left   = 2'd0;
        code_acc    = '0;
        burst_left  = 0;
        calm_phase  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_escapes();
        test_multibyte();
        wait_drained();
        test_dropped_bytes();
        test_random_text();

        wait_drained();
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("tb_utf8_escape_formatter_unit: PASS");
        else
            $display("tb_utf8_escape_formatter_unit: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/uef_pkg.sv
hdl/uef_front.sv
hdl/uef_queue.sv
hdl/uef_back.sv
hdl/utf8_escape_formatter_unit.sv
hdl/uef_checker.sv
bench/tb_utf8_escape_formatter_unit.sv
